// ----- src/b64_pkg.sv -----
// b64_pkg: shared types, codes and character mapping for the base64 codec
// no dependencies

package b64_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = 1;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_TRUNC    = 2'd2
  } b64_status_t;

  // one group of results waiting for the output side
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    logic            last;
    logic [1:0]      status;
  } b64_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } b64_qstat_t;

  function automatic logic [7:0] enc_char(input logic [5:0] s);
    logic [7:0] c;
    if (s < 6'd26) begin
      c = 8'd65 + {2'b00, s};
    end else if (s < 6'd52) begin
      c = 8'd97 + {2'b00, s} - 8'd26;
    end else if (s < 6'd62) begin
      c = 8'd48 + {2'b00, s} - 8'd52;
    end else if (s == 6'd62) begin
      c = 8'd43;
    end else begin
      c = 8'd47;
    end
    return c;
  endfunction

  // returns {valid, sextet}
  function automatic logic [6:0] dec_sextet(input logic [7:0] c);
    logic [6:0] r;
    if (c >= 8'd65 && c <= 8'd90) begin
      r = {1'b1, 6'(c - 8'd65)};
    end else if (c >= 8'd97 && c <= 8'd122) begin
      r = {1'b1, 6'(c - 8'd97 + 8'd26)};
    end else if (c >= 8'd48 && c <= 8'd57) begin
      r = {1'b1, 6'(c - 8'd48 + 8'd52)};
    end else if (c == 8'd43) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'd47) begin
      r = {1'b1, 6'd63};
    end else begin
      r = 7'd0;
    end
    return r;
  endfunction

endpackage

// ----- src/b64_in_if.sv -----
// b64_in_if: input channel, valid/ready handshake with byte and last flag
// no dependencies

interface b64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ----- src/b64_out_if.sv -----
// b64_out_if: output channel, valid/ready handshake with byte, last flag and status
// no dependencies

interface b64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic [1:0] status;

  modport source (output valid, output out_byte, output out_last, output status,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input status,
                  output ready);
endinterface

// ----- src/b64_front.sv -----
// b64_front: mode register, group gathering and classification into result groups
// depends on b64_pkg and b64_in_if

module b64_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_data,
  b64_in_if.sink            din,
  input  b64_pkg::b64_qstat_t qstat,
  output logic              push,
  output b64_pkg::b64_job_t job
);
  import b64_pkg::*;

  logic        decode_mode;
  logic [1:0]  group_count;
  logic [17:0] group_bits;
  logic        third_is_pad;
  logic        bad_char_seen;

  logic [1:0]  group_count_next;
  logic [17:0] group_bits_next;
  logic        third_is_pad_next;
  logic        bad_char_seen_next;

  logic        acc;
  logic        fire;
  logic [2:0]  n3;
  logic [2:0]  chars;
  logic [17:0] enc_bits;
  logic [23:0] word;
  logic        pad;
  logic [6:0]  dec;
  logic        bad_new;

  assign din.ready = !qstat.full;
  assign acc       = din.valid && din.ready;
  assign push      = acc && fire;

  always_comb begin
    n3                 = {1'b0, group_count} + 3'd1;
    chars              = n3 + 3'd1;
    enc_bits           = {group_bits[9:0], din.in_byte};
    pad                = (din.in_byte == PAD_CHAR);
    dec                = dec_sextet(din.in_byte);
    bad_new            = bad_char_seen | (!pad & !dec[6]);
    word               = '0;
    fire               = 1'b0;
    job                = '0;
    group_count_next   = group_count;
    group_bits_next    = group_bits;
    third_is_pad_next  = third_is_pad;
    bad_char_seen_next = bad_char_seen;

    if (decode_mode == MODE_ENCODE) begin
      if (n3 == 3'd3) begin
        word = {6'd0, enc_bits};
      end else if (n3 == 3'd2) begin
        word = {enc_bits[15:0], 8'd0};
      end else begin
        word = {din.in_byte, 16'd0};
      end
      fire = (n3 == 3'd3) || din.in_last;
      for (int k = 0; k < 4; k++) begin
        job.bytes[k] = (3'(k) < chars) ? enc_char(word[(3 - k) * 6 +: 6]) : PAD_CHAR;
      end
      job.cnt    = 3'd4;
      job.last   = din.in_last;
      job.status = ST_OK;
      if (fire) begin
        group_count_next   = '0;
        group_bits_next    = '0;
        third_is_pad_next  = 1'b0;
        bad_char_seen_next = 1'b0;
      end else begin
        group_count_next = n3[1:0];
        group_bits_next  = enc_bits;
      end
    end else begin
      word = {group_bits, dec[5:0] & {6{!pad}}};
      if (n3 == 3'd4) begin
        fire         = 1'b1;
        job.bytes[0] = word[23:16];
        job.bytes[1] = word[15:8];
        job.bytes[2] = word[7:0];
        job.cnt      = 3'd3 - 3'(din.in_last & pad) - 3'(din.in_last & third_is_pad);
        job.last     = din.in_last;
        job.status   = bad_new ? ST_BAD_CHAR : ST_OK;
      end else if (din.in_last) begin
        fire       = 1'b1;
        job.cnt    = 3'd1;
        job.last   = 1'b1;
        job.status = ST_TRUNC;
      end
      if (fire) begin
        group_count_next   = '0;
        group_bits_next    = '0;
        third_is_pad_next  = 1'b0;
        bad_char_seen_next = 1'b0;
      end else begin
        group_count_next   = n3[1:0];
        group_bits_next    = word[17:0];
        bad_char_seen_next = bad_new;
        if (n3 == 3'd3) begin
          third_is_pad_next = pad;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode   <= MODE_ENCODE;
      group_count   <= '0;
      group_bits    <= '0;
      third_is_pad  <= 1'b0;
      bad_char_seen <= 1'b0;
    end else if (cfg_we) begin
      decode_mode   <= cfg_data;
      group_count   <= '0;
      group_bits    <= '0;
      third_is_pad  <= 1'b0;
      bad_char_seen <= 1'b0;
    end else if (acc) begin
      group_count   <= group_count_next;
      group_bits    <= group_bits_next;
      third_is_pad  <= third_is_pad_next;
      bad_char_seen <= bad_char_seen_next;
    end
  end

endmodule

// ----- src/b64_queue.sv -----
// b64_queue: short queue of result groups between front and back
// depends on b64_pkg

module b64_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  b64_pkg::b64_job_t   wr_job,
  input  logic                pop,
  output b64_pkg::b64_job_t   rd_job,
  output b64_pkg::b64_qstat_t qstat
);
  import b64_pkg::*;

  b64_job_t         slots [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     count;

  assign rd_job      = slots[rd_ptr];
  assign qstat.full  = (count == (QAW + 1)'(QDEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QAW + 1)'(push) - (QAW + 1)'(pop);
    end
  end

endmodule

// ----- src/b64_back.sv -----
// b64_back: walks each result group one item per cycle into the output register
// when not stalled by dout.ready; depends on b64_pkg and b64_out_if

module b64_back (
  input  logic                clk,
  input  logic                rst,
  input  b64_pkg::b64_job_t   job,
  input  b64_pkg::b64_qstat_t qstat,
  output logic                pop,
  b64_out_if.source           dout
);
  import b64_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       final_item;

  assign load       = !dout.valid || dout.ready;
  assign final_item = (({1'b0, idx} + 3'd1) == job.cnt);
  assign pop        = load && !qstat.empty && final_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
      idx        <= '0;
    end else if (load) begin
      dout.valid <= !qstat.empty;
      if (!qstat.empty) begin
        idx <= final_item ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !qstat.empty) begin
      dout.out_byte <= job.bytes[idx];
      dout.out_last <= job.last && final_item;
      dout.status   <= job.status;
    end
  end

endmodule

// ----- src/base64_stream_codec.sv -----
// base64_stream_codec: base64 encoder/decoder over a byte stream, top level
// depends on b64_pkg, b64_in_if, b64_out_if, b64_front, b64_queue, b64_back
//
//   channel   | dir | handshake     | payload
//   ----------+-----+---------------+-------------------------------
//   din       | in  | valid / ready | in_byte[7:0], in_last
//   dout      | out | valid / ready | out_byte[7:0], out_last, status[1:0]
//   cfg       | in  | cfg_we        | cfg_data (decode_mode)
//
// an item is taken every cycle while the two-group queue has room
// the output side emits one item per cycle when not stalled, so encoding
// sustains 4 results per 3 items, decoding one item per cycle
// a closing item's group is queued, then its first result registered in dout
// rst is synchronous and clears mode, group state, queue and output valid
// a stalled output fills the queue, then din.ready drops

module base64_stream_codec (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_data,
  b64_in_if.sink    din,
  b64_out_if.source dout
);
  import b64_pkg::*;

  b64_job_t   f_job;
  b64_job_t   q_job;
  b64_qstat_t qstat;
  logic       q_push;
  logic       q_pop;

  b64_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .din      (din),
    .qstat    (qstat),
    .push     (q_push),
    .job      (f_job)
  );

  b64_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_job (f_job),
    .pop    (q_pop),
    .rd_job (q_job),
    .qstat  (qstat)
  );

  b64_back u_back (
    .clk   (clk),
    .rst   (rst),
    .job   (q_job),
    .qstat (qstat),
    .pop   (q_pop),
    .dout  (dout)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !qstat.full)
    else $error("group pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !qstat.empty)
    else $error("group popped from empty queue");

  a_trunc_form: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && dout.status == ST_TRUNC) |-> (dout.out_last && dout.out_byte == 8'd0))
    else $error("truncated group result malformed");
`endif

endmodule
